@@ rtl/assert_macros.svh @@
// Assertion macros for the ring engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same check, for properties that must also hold while reset is held.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/chr_pkg.sv @@
// Package with the types and constants of the consistent-hash ring engine.
`timescale 1ns / 1ps

package chr_pkg;

  localparam int RING_DEPTH_DEF = 256;
  localparam int GROUP_SIZE     = 16;
  localparam int HASH_W         = 31;
  localparam int RUN_W          = 32;
  localparam int NODE_W         = 8;
  localparam int BYTE_W         = 8;
  localparam logic [13:0] BKDR_SEED = 14'd13131;

  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_LOOKUP = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_EMPTY   = 3'd1,
    STAT_DUP     = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_MISSING = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RED,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [NODE_W-1:0] owner;
  } cell_data_t;

  // Broadcast to every cell: the command hash, the node id and the one-cycle update strobes.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [HASH_W-1:0] h;
    logic [NODE_W-1:0] node;
  } ring_cmd_t;

  typedef struct packed {
    logic sel;    // empty cell or stored hash >= command hash
    logic hit;    // occupied cell holding exactly the command hash
    logic first;  // lowest occupied cell at or above the command hash
  } cell_flags_t;

endpackage

@@ rtl/chr_hash.sv @@
// Running BKDR hash accumulator over the streamed key bytes.
`timescale 1ns / 1ps

module chr_hash (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        byte_en,
  input  logic                        clear,
  input  logic [chr_pkg::BYTE_W-1:0]  data_byte,
  output logic [chr_pkg::RUN_W-1:0]   hash
);

  logic [chr_pkg::RUN_W-1:0] hash_r;
  logic [chr_pkg::RUN_W-1:0] hash_nxt;
  logic [chr_pkg::RUN_W-1:0] byte_ext;
  logic [chr_pkg::RUN_W-1:0] product;

  // The key byte is a signed char.
  assign byte_ext = {{(chr_pkg::RUN_W-chr_pkg::BYTE_W){data_byte[chr_pkg::BYTE_W-1]}},
                     data_byte};
  assign product  = chr_pkg::RUN_W'(hash_r * {{(chr_pkg::RUN_W-14){1'b0}},
                                               chr_pkg::BKDR_SEED});

  always_comb begin
    hash_nxt = hash_r;
    priority if (clear) begin
      hash_nxt = '0;
    end else if (byte_en) begin
      hash_nxt = product + byte_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
    end else begin
      hash_r <= hash_nxt;
    end
  end

  assign hash = hash_r;

endmodule

@@ rtl/chr_cell.sv @@
// One point of the sorted ring: stored hash and owner, compare flags, shift logic.
`timescale 1ns / 1ps

module chr_cell (
  input  logic                 clk,
  input  chr_pkg::ring_cmd_t   cmd,
  input  logic                 occ,
  input  logic                 left_sel,
  input  chr_pkg::cell_data_t  left_data,
  input  chr_pkg::cell_data_t  right_data,
  output chr_pkg::cell_data_t  data,
  output chr_pkg::cell_flags_t flags
);

  chr_pkg::cell_data_t data_r;
  chr_pkg::cell_data_t data_nxt;
  logic                sel_r;
  logic                sel_nxt;
  logic                hit_r;
  logic                hit_nxt;

  assign sel_nxt = !occ || (data_r.hash >= cmd.h);
  assign hit_nxt = occ && (data_r.hash == cmd.h);

  // Insert: cells at and above the slot take their left neighbor, the slot
  // itself takes the new point. Remove: cells from the match upward take their
  // right neighbor.
  always_comb begin
    data_nxt = data_r;
    priority if (cmd.ins && sel_r) begin
      if (left_sel) begin
        data_nxt = left_data;
      end else begin
        data_nxt.hash  = cmd.h;
        data_nxt.owner = cmd.node;
      end
    end else if (cmd.rem && sel_r) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    sel_r  <= sel_nxt;
    hit_r  <= hit_nxt;
  end

  assign data        = data_r;
  assign flags.sel   = sel_r;
  assign flags.hit   = hit_r;
  assign flags.first = occ && sel_r && !left_sel;

endmodule

@@ rtl/consistent_hash_ring.sv @@
// Top level of the consistent-hash ring engine: handshake, control and the cell chain.
// Key bytes are accepted back to back while no command is in flight.
// A command (insert, remove, lookup) runs through four steps: accept, compare in every cell,
// grouped flag reduction, final reduction with ring update. Its result is registered at the
// update, which stalls while an earlier result is not yet taken; no key byte or command is taken until then.
// rst_n is synchronous and active low; it clears the running hash, the point count, the state and out_valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module consistent_hash_ring #(
  parameter int RING_DEPTH = chr_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic [chr_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic [chr_pkg::NODE_W-1:0]    in_node_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_status,
  output logic [chr_pkg::NODE_W-1:0]    out_owner_node,
  output logic [chr_pkg::HASH_W-1:0]    out_key_hash
);

  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int GS    = chr_pkg::GROUP_SIZE;
  localparam int NGRP  = (RING_DEPTH + GS - 1) / GS;

  chr_pkg::state_t  state_r, state_nxt;
  chr_pkg::opcode_t op_r;
  logic [chr_pkg::HASH_W-1:0] h_r;
  logic [chr_pkg::NODE_W-1:0] node_r;
  logic [CNT_W-1:0]           count_r, count_nxt;

  logic                       out_valid_r, out_valid_nxt;
  chr_pkg::status_t           out_status_r, status_nxt;
  logic [chr_pkg::NODE_W-1:0] out_owner_r, owner_nxt;
  logic [chr_pkg::HASH_W-1:0] out_hash_r;

  logic                       accept;
  logic                       is_key;
  logic                       out_free;
  logic                       apply_go;
  logic [chr_pkg::RUN_W-1:0]  run_hash;

  chr_pkg::ring_cmd_t         cmd;
  logic                       do_ins, do_rem;
  chr_pkg::cell_data_t        cell_data  [RING_DEPTH];
  chr_pkg::cell_flags_t       cell_flags [RING_DEPTH];
  logic [RING_DEPTH-1:0]      occ;

  logic [NGRP-1:0]            grp_hit_r, grp_hit_nxt;
  logic [NGRP-1:0]            grp_first_r, grp_first_nxt;
  logic [chr_pkg::NODE_W-1:0] grp_own_r [NGRP];
  logic [chr_pkg::NODE_W-1:0] grp_own_nxt [NGRP];
  logic                       hit_any, first_any;
  logic [chr_pkg::NODE_W-1:0] own_any;
  logic                       ring_full, ring_empty;

  assign accept   = in_valid && in_ready;
  assign is_key   = (in_opcode == chr_pkg::OP_KEY);
  assign out_free = !out_valid_r || out_ready;

  chr_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (accept && is_key),
    .clear     (accept && !is_key),
    .data_byte (in_data_byte),
    .hash      (run_hash)
  );

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      chr_pkg::S_IDLE:  if (accept && !is_key) state_nxt = chr_pkg::S_CMP;
      chr_pkg::S_CMP:   state_nxt = chr_pkg::S_RED;
      chr_pkg::S_RED:   state_nxt = chr_pkg::S_APPLY;
      chr_pkg::S_APPLY: if (out_free) state_nxt = chr_pkg::S_IDLE;
      default:          state_nxt = chr_pkg::S_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready = 1'b0;
    apply_go = 1'b0;
    unique case (state_r)
      chr_pkg::S_IDLE:  in_ready = 1'b1;
      chr_pkg::S_APPLY: apply_go = out_free;
      default: begin
        in_ready = 1'b0;
        apply_go = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Command capture; the hash is masked to 31 bits here.
  always_ff @(posedge clk) begin
    if (accept && !is_key) begin
      op_r   <= chr_pkg::opcode_t'(in_opcode);
      h_r    <= run_hash[chr_pkg::HASH_W-1:0];
      node_r <= in_node_id;
    end
  end

  // Cell chain.
  always_comb begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      occ[i] = (CNT_W'(i) < count_r);
    end
  end

  assign cmd.ins  = do_ins;
  assign cmd.rem  = do_rem;
  assign cmd.h    = h_r;
  assign cmd.node = node_r;

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    chr_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occ        (occ[i]),
      .left_sel   ((i == 0) ? 1'b0 : cell_flags[(i == 0) ? 0 : i - 1].sel),
      .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
      .right_data (cell_data[(i == RING_DEPTH - 1) ? i : i + 1]),
      .data       (cell_data[i]),
      .flags      (cell_flags[i])
    );
  end

  // First reduction level: groups of cells, registered.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit_nxt[g]   = 1'b0;
      grp_first_nxt[g] = 1'b0;
      grp_own_nxt[g]   = '0;
      for (int k = 0; k < GS; k++) begin
        if (g * GS + k < RING_DEPTH) begin
          grp_hit_nxt[g]   = grp_hit_nxt[g] | cell_flags[g * GS + k].hit;
          grp_first_nxt[g] = grp_first_nxt[g] | cell_flags[g * GS + k].first;
          grp_own_nxt[g]   = grp_own_nxt[g] |
                             ({chr_pkg::NODE_W{cell_flags[g * GS + k].first}} &
                              cell_data[g * GS + k].owner);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_hit_r   <= grp_hit_nxt;
    grp_first_r <= grp_first_nxt;
    for (int g = 0; g < NGRP; g++) begin
      grp_own_r[g] <= grp_own_nxt[g];
    end
  end

  // Final reduction over the groups.
  always_comb begin
    own_any = '0;
    for (int g = 0; g < NGRP; g++) begin
      own_any = own_any | grp_own_r[g];
    end
  end

  assign hit_any    = |grp_hit_r;
  assign first_any  = |grp_first_r;
  assign ring_full  = (count_r == CNT_W'(RING_DEPTH));
  assign ring_empty = (count_r == '0);

  // Decision and result for the command in flight.
  always_comb begin
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    status_nxt = chr_pkg::STAT_OK;
    owner_nxt  = '0;
    count_nxt  = count_r;
    unique case (op_r)
      chr_pkg::OP_INSERT: begin
        priority if (hit_any) begin
          status_nxt = chr_pkg::STAT_DUP;
        end else if (ring_full) begin
          status_nxt = chr_pkg::STAT_FULL;
        end else begin
          do_ins    = apply_go;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      chr_pkg::OP_REMOVE: begin
        if (hit_any) begin
          do_rem    = apply_go;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = chr_pkg::STAT_MISSING;
        end
      end
      chr_pkg::OP_LOOKUP: begin
        priority if (ring_empty) begin
          status_nxt = chr_pkg::STAT_EMPTY;
        end else if (first_any) begin
          owner_nxt = own_any;
        end else begin
          // Above the highest point the ring wraps to the lowest one.
          owner_nxt = cell_data[0].owner;
        end
      end
      default: begin
        status_nxt = chr_pkg::STAT_OK;
      end
    endcase
  end

  assign out_valid_nxt = apply_go ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (apply_go) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      out_status_r <= status_nxt;
      out_owner_r  <= owner_nxt;
      out_hash_r   <= h_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_owner_node = out_owner_r;
  assign out_key_hash   = out_hash_r;

  `ASSERT_CLK(a_count_bound, count_r <= CNT_W'(RING_DEPTH), "point count exceeds ring depth")
  `ASSERT_CLK(a_result_from_apply, $rose(out_valid_r) |-> $past(state_r == chr_pkg::S_APPLY), "result appeared outside the apply step")
  `ASSERT_CLK(a_count_from_apply, !$stable(count_r) |-> $past(state_r == chr_pkg::S_APPLY), "point count moved outside the apply step")
  `ASSERT_CLK(a_owner_zero, (out_valid_r && out_status_r != chr_pkg::STAT_OK) |-> (out_owner_r == '0), "owner set on a failed command")

endmodule
